// ===== sv/vcag_pkg.sv =====
package vcag_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int CURVE_TABLE_ENTRIES = 256;
    localparam int IDX_BITS            = $clog2(CURVE_TABLE_ENTRIES);

    localparam logic [1:0] MODE_LIN = 2'd0;
    localparam logic [1:0] MODE_EXP = 2'd1;
    localparam logic [1:0] MODE_LOG = 2'd2;

    localparam logic [2:0] REG_RESPONSE_MODE  = 3'd0;
    localparam logic [2:0] REG_BASE_GAIN      = 3'd1;
    localparam logic [2:0] REG_CV_SENSITIVITY = 3'd2;
    localparam logic [2:0] REG_GAIN_FLOOR     = 3'd3;
    localparam logic [2:0] REG_GAIN_CEILING   = 3'd4;
    localparam logic [2:0] REG_CV_FLOOR       = 3'd5;
    localparam logic [2:0] REG_CV_CEILING     = 3'd6;
    localparam logic [2:0] REG_CV_FS_INVERSE  = 3'd7;

    localparam logic [15:0]        SENS_MAX  = 16'd40960;
    localparam logic [29:0]        EXP_K_Q32 = 30'd619632802;
    localparam logic signed [21:0] LN2_Q16   = 22'sd45426;
    localparam logic signed [21:0] LN_MIN    = -22'sd452707;
    localparam longint unsigned    LN2_Q32   = 64'd2977044472;

    typedef logic [31:0] t_tab [0:CURVE_TABLE_ENTRIES];

    function automatic t_tab build_exp_tab();
        t_tab tab;
        longint unsigned u;
        longint unsigned term;
        longint unsigned sum;
        for (int k = 0; k <= CURVE_TABLE_ENTRIES; k++) begin
            u    = (64'(k) * LN2_Q32) / 64'(CURVE_TABLE_ENTRIES);
            term = 64'h1_0000_0000;
            sum  = 64'h1_0000_0000;
            for (int j = 1; j <= 24; j++) begin
                term = ((term * u) >> 32) / 64'(j);
                sum  = sum + term;
            end
            tab[k] = 32'(sum >> 2);
        end
        return tab;
    endfunction

    function automatic t_tab build_ln_tab();
        t_tab tab;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned acc;
        for (int k = 0; k <= CURVE_TABLE_ENTRIES; k++) begin
            z   = (64'(k) << 32) / 64'(2 * CURVE_TABLE_ENTRIES + k);
            z2  = (z * z) >> 32;
            p   = z;
            acc = 64'd0;
            for (int j = 0; j < 24; j++) begin
                acc = acc + p / 64'(2 * j + 1);
                p   = (p * z2) >> 32;
            end
            tab[k] = 32'((acc << 1) >> 2);
        end
        return tab;
    endfunction

    localparam t_tab EXP_TAB = build_exp_tab();
    localparam t_tab LN_TAB  = build_ln_tab();

endpackage

// ===== sv/voltage_controlled_amplifier_gain.sv =====
// Channel   Handshake                     Payload
// input     i_valid / o_stall             i_sample_in, i_control_volts
// output    o_valid / i_stall             o_sample_out, o_applied_gain, o_clipped
// config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// Eight register stages; one item per cycle while the output is not stalled.
// The wide products and the curve table read set the depth of each stage.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output freezes every stage; no item is dropped or repeated.
module voltage_controlled_amplifier_gain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [vcag_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [15:0]                  i_control_volts,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [vcag_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic [23:0]                         o_applied_gain,
    output logic                                o_clipped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [2:0]                          i_cfg_index,
    input  logic [23:0]                         i_cfg_data
);

    localparam int SB = vcag_pkg::SAMPLE_BITS;
    localparam logic signed [SB+8:0] YMAX = {{10{1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SB+8:0] YMIN = {{10{1'b1}}, {(SB-1){1'b0}}};

    logic [1:0]         r_response_mode;
    logic [23:0]        r_base_gain;
    logic [15:0]        r_cv_sensitivity;
    logic [23:0]        r_gain_floor;
    logic [23:0]        r_gain_ceiling;
    logic signed [15:0] r_cv_floor;
    logic signed [15:0] r_cv_ceiling;
    logic [15:0]        r_cv_fs_inverse;

    logic       en;
    logic [8:1] r_vld;

    // stage 1
    logic signed [15:0] n_cv;
    logic [23:0]        n_g;
    logic [15:0]        n_sens;
    logic signed [SB-1:0] r1_smp;
    logic signed [15:0] r1_cv;
    logic [23:0]        r1_g;
    logic [15:0]        r1_sens;
    logic signed [32:0] r1_cs;
    logic signed [32:0] r1_ci;

    // stage 2
    logic signed [49:0] n2_lp;
    logic signed [63:0] n2_ek;
    logic [3:0]         n2_p;
    logic [30:0]        n2_mfull;
    logic signed [SB-1:0] r2_smp;
    logic [23:0]        r2_g;
    logic [15:0]        r2_sens;
    logic signed [49:0] r2_lp;
    logic signed [24:0] r2_t;
    logic [3:0]         r2_p;
    logic [15:0]        r2_m16;
    logic               r2_small;

    // stage 3
    logic signed [8:0]  n3_i;
    logic signed [8:0]  n3_ic;
    logic signed [8:0]  n3_sh;
    logic signed [27:0] n3_flin;
    logic [31:0]        lk_base;
    logic [31:0]        lk_step;
    logic signed [SB-1:0] r3_smp;
    logic [23:0]        r3_g;
    logic [15:0]        r3_sens;
    logic signed [27:0] r3_flin;
    logic [6:0]         r3_sh;
    logic [3:0]         r3_p;
    logic               r3_small;

    // stage 4
    logic [31:0]        n4_val;
    logic signed [4:0]  n4_pn;
    logic signed [21:0] n4_lnq;
    logic signed [SB-1:0] r4_smp;
    logic [23:0]        r4_g;
    logic signed [27:0] r4_flin;
    logic [6:0]         r4_sh;
    logic [31:0]        r4_mant;
    logic signed [38:0] r4_ls;

    // stage 5
    logic signed [32:0] n5_x;
    logic [6:0]         n5_sh;
    logic signed [SB-1:0] r5_smp;
    logic signed [57:0] r5_prod;
    logic [6:0]         r5_sh;

    // stage 6
    logic signed [57:0] n6_eff;
    logic [23:0]        n6_effc;
    logic signed [SB-1:0] r6_smp;
    logic [23:0]        r6_eff;

    // stage 7
    logic signed [SB+24:0] r7_y;
    logic [23:0]           r7_eff;

    // stage 8
    logic signed [SB+8:0]  n8_ys;
    logic signed [SB-1:0]  r8_y;
    logic [23:0]           r8_eff;
    logic                  r8_clip;

    assign en          = !(r_vld[8] && i_stall);
    assign o_stall     = r_vld[8] && i_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_mode  <= vcag_pkg::MODE_LIN;
            r_base_gain      <= 24'd65536;
            r_cv_sensitivity <= 16'd4096;
            r_gain_floor     <= 24'd0;
            r_gain_ceiling   <= 24'd655360;
            r_cv_floor       <= -16'sd20480;
            r_cv_ceiling     <= 16'sd20480;
            r_cv_fs_inverse  <= 16'd6554;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vcag_pkg::REG_RESPONSE_MODE:  r_response_mode  <= i_cfg_data[1:0];
                vcag_pkg::REG_BASE_GAIN:      r_base_gain      <= i_cfg_data;
                vcag_pkg::REG_CV_SENSITIVITY: r_cv_sensitivity <= i_cfg_data[15:0];
                vcag_pkg::REG_GAIN_FLOOR:     r_gain_floor     <= i_cfg_data;
                vcag_pkg::REG_GAIN_CEILING:   r_gain_ceiling   <= i_cfg_data;
                vcag_pkg::REG_CV_FLOOR:       r_cv_floor       <= $signed(i_cfg_data[15:0]);
                vcag_pkg::REG_CV_CEILING:     r_cv_ceiling     <= $signed(i_cfg_data[15:0]);
                vcag_pkg::REG_CV_FS_INVERSE:  r_cv_fs_inverse  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[7:1], i_valid};
        end
    end

    always_comb begin
        n_cv = i_control_volts;
        if (n_cv > r_cv_ceiling) n_cv = r_cv_ceiling;
        if (n_cv < r_cv_floor)   n_cv = r_cv_floor;
        n_g = r_base_gain;
        if (n_g > r_gain_ceiling) n_g = r_gain_ceiling;
        if (n_g < r_gain_floor)   n_g = r_gain_floor;
        n_sens = (r_cv_sensitivity > vcag_pkg::SENS_MAX) ? vcag_pkg::SENS_MAX
                                                         : r_cv_sensitivity;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_smp  <= i_sample_in;
            r1_cv   <= n_cv;
            r1_g    <= n_g;
            r1_sens <= n_sens;
            r1_cs   <= n_cv * $signed({1'b0, n_sens});
            r1_ci   <= n_cv * $signed({1'b0, r_cv_fs_inverse});
        end
    end

    always_comb begin
        n2_lp = r1_ci * $signed({1'b0, r1_sens});
        n2_ek = 64'(r1_cs) * 64'($signed({1'b0, vcag_pkg::EXP_K_Q32}));
        n2_p  = 4'd0;
        for (int b = 1; b < 15; b++) begin
            if (r1_cv[b]) n2_p = 4'(b);
        end
        n2_mfull = {r1_cv[14:0], 16'd0} >> n2_p;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_smp   <= r1_smp;
            r2_g     <= r1_g;
            r2_sens  <= r1_sens;
            r2_lp    <= n2_lp;
            r2_t     <= n2_ek[63:39];
            r2_p     <= n2_p;
            r2_m16   <= n2_mfull[15:0];
            r2_small <= (r1_cv < 16'sd3);
        end
    end

    always_comb begin
        n3_flin = {r2_lp[49], r2_lp[49:23]} + 28'sd65536;
        n3_i    = r2_t[24:16];
        n3_ic   = n3_i;
        if (n3_ic > 9'sd29)  n3_ic = 9'sd29;
        if (n3_ic < -9'sd40) n3_ic = -9'sd40;
        n3_sh   = 9'sd30 - n3_ic;
    end

    vcag_lookup u_lookup (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_use_ln (r_response_mode == vcag_pkg::MODE_LOG),
        .i_frac   ((r_response_mode == vcag_pkg::MODE_LOG) ? r2_m16 : r2_t[15:0]),
        .o_base   (lk_base),
        .o_step   (lk_step)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_smp   <= r2_smp;
            r3_g     <= r2_g;
            r3_sens  <= r2_sens;
            r3_flin  <= n3_flin;
            r3_sh    <= n3_sh[6:0];
            r3_p     <= r2_p;
            r3_small <= r2_small;
        end
    end

    always_comb begin
        n4_val = lk_base + lk_step;
        n4_pn  = $signed({1'b0, r3_p}) - 5'sd11;
        if (r3_small) begin
            n4_lnq = vcag_pkg::LN_MIN;
        end else begin
            n4_lnq = 22'(n4_pn) * vcag_pkg::LN2_Q16 + $signed({4'd0, n4_val[31:14]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_smp  <= r3_smp;
            r4_g    <= r3_g;
            r4_flin <= r3_flin;
            r4_sh   <= r3_sh;
            r4_mant <= n4_val;
            r4_ls   <= 39'(n4_lnq) * 39'($signed({1'b0, r3_sens}));
        end
    end

    always_comb begin
        case (r_response_mode)
            vcag_pkg::MODE_LIN: begin
                n5_x  = 33'(r4_flin);
                n5_sh = 7'd16;
            end
            vcag_pkg::MODE_EXP: begin
                n5_x  = $signed({1'b0, r4_mant});
                n5_sh = r4_sh;
            end
            vcag_pkg::MODE_LOG: begin
                n5_x  = 33'($signed(r4_ls[38:12])) + 33'sd65536;
                n5_sh = 7'd16;
            end
            default: begin
                n5_x  = 33'sd1;
                n5_sh = 7'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_smp  <= r4_smp;
            r5_prod <= 58'($signed({1'b0, r4_g})) * 58'(n5_x);
            r5_sh   <= n5_sh;
        end
    end

    always_comb begin
        n6_eff  = (r5_sh >= 7'd64) ? 58'sd0 : (r5_prod >>> r5_sh[5:0]);
        n6_effc = n6_eff[23:0];
        if (n6_eff > $signed({34'd0, r_gain_ceiling})) begin
            n6_effc = r_gain_ceiling;
        end
        if (n6_eff < $signed({34'd0, r_gain_floor}) || n6_effc < r_gain_floor) begin
            n6_effc = r_gain_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_smp <= r5_smp;
            r6_eff <= n6_effc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_y   <= (SB+25)'(r6_smp) * (SB+25)'($signed({1'b0, r6_eff}));
            r7_eff <= r6_eff;
        end
    end

    assign n8_ys = r7_y[SB+24:16];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_eff <= r7_eff;
            if (n8_ys > YMAX) begin
                r8_y    <= YMAX[SB-1:0];
                r8_clip <= 1'b1;
            end else if (n8_ys < YMIN) begin
                r8_y    <= YMIN[SB-1:0];
                r8_clip <= 1'b1;
            end else begin
                r8_y    <= n8_ys[SB-1:0];
                r8_clip <= 1'b0;
            end
        end
    end

    assign o_valid        = r_vld[8];
    assign o_sample_out   = r8_y;
    assign o_applied_gain = r8_eff;
    assign o_clipped      = r8_clip;

endmodule

// ===== sv/vcag_lookup.sv =====
module vcag_lookup (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_use_ln,
    input  logic [15:0] i_frac,
    output logic [31:0] o_base,
    output logic [31:0] o_step
);

    localparam int PW = 16 + vcag_pkg::IDX_BITS;

    logic [PW-1:0]                   pos;
    logic [vcag_pkg::IDX_BITS:0]     idx0;
    logic [vcag_pkg::IDX_BITS:0]     idx1;
    logic [15:0]                     rem;
    logic [31:0]                     lo;
    logic [31:0]                     hi;
    logic [31:0]                     diff;
    logic [47:0]                     prod;
    logic [31:0]                     r_base;
    logic [31:0]                     r_step;

    always_comb begin
        pos  = PW'(i_frac) * PW'(vcag_pkg::CURVE_TABLE_ENTRIES);
        idx0 = {1'b0, pos[PW-1:16]};
        idx1 = idx0 + 1'b1;
        rem  = pos[15:0];
        if (i_use_ln) begin
            lo = vcag_pkg::LN_TAB[idx0];
            hi = vcag_pkg::LN_TAB[idx1];
        end else begin
            lo = vcag_pkg::EXP_TAB[idx0];
            hi = vcag_pkg::EXP_TAB[idx1];
        end
        diff = hi - lo;
        prod = 48'(diff) * 48'(rem);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base <= lo;
            r_step <= prod[47:16];
        end
    end

    assign o_base = r_base;
    assign o_step = r_step;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    localparam int TAB_N     = vcag_pkg::CURVE_TABLE_ENTRIES;
    localparam int SBITS     = vcag_pkg::SAMPLE_BITS;
    localparam int MAX_CYCLES = 400000;
    localparam int PHASES    = 12;
    localparam int PER_PHASE = 145;

    typedef struct {
        logic signed [SBITS-1:0] sample;
        logic [23:0]             gain;
        logic                    clip;
    } t_vca_result;

    class t_vca_scoreboard;
        logic [23:0]       regs [8];
        longint unsigned   pow2_tab [0:TAB_N];
        longint unsigned   log_tab [0:TAB_N];
        t_vca_result       pending_out [$];
        int                mismatches;
        int                matched;

        function new();
            longint unsigned u, term, sum, z, z2, p, acc;
            for (int k = 0; k <= TAB_N; k++) begin
                u    = (longint'(k) * vcag_pkg::LN2_Q32) / TAB_N;
                term = 64'h1_0000_0000;
                sum  = 64'h1_0000_0000;
                for (int j = 1; j <= 24; j++) begin
                    term = ((term * u) >> 32) / j;
                    sum += term;
                end
                pow2_tab[k] = sum >> 2;
                z   = (longint'(k) << 32) / (2 * TAB_N + k);
                z2  = (z * z) >> 32;
                p   = z;
                acc = 0;
                for (int j = 0; j < 24; j++) begin
                    acc += p / (2 * j + 1);
                    p = (p * z2) >> 32;
                end
                log_tab[k] = (2 * acc) >> 2;
            end
            regs[vcag_pkg::REG_RESPONSE_MODE]  = 24'(vcag_pkg::MODE_LIN);
            regs[vcag_pkg::REG_BASE_GAIN]      = 24'd65536;
            regs[vcag_pkg::REG_CV_SENSITIVITY] = 24'd4096;
            regs[vcag_pkg::REG_GAIN_FLOOR]     = 24'd0;
            regs[vcag_pkg::REG_GAIN_CEILING]   = 24'd655360;
            regs[vcag_pkg::REG_CV_FLOOR]       = 24'(16'hB000);
            regs[vcag_pkg::REG_CV_CEILING]     = 24'd20480;
            regs[vcag_pkg::REG_CV_FS_INVERSE]  = 24'd6554;
            mismatches = 0;
            matched    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                vcag_pkg::REG_RESPONSE_MODE: regs[idx] = data & 24'h3;
                vcag_pkg::REG_BASE_GAIN, vcag_pkg::REG_GAIN_FLOOR,
                vcag_pkg::REG_GAIN_CEILING: regs[idx] = data;
                default: regs[idx] = data & 24'hFFFF;
            endcase
        endfunction

        function longint unsigned curve(bit is_log, longint unsigned f16);
            longint unsigned pos, idx, rem, a, b;
            pos = (f16 & 64'hFFFF) * TAB_N;
            idx = pos >> 16;
            rem = pos & 64'hFFFF;
            if (idx >= TAB_N) idx = TAB_N - 1;
            a = is_log ? log_tab[idx] : pow2_tab[idx];
            b = is_log ? log_tab[idx + 1] : pow2_tab[idx + 1];
            return a + (((b - a) * rem) >> 16);
        endfunction

        function longint clampl(longint v, longint lo, longint hi);
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v;
        endfunction

        function void note_input(logic signed [SBITS-1:0] smp_in,
                                 logic signed [15:0] cv_in);
            longint smp, cv, gf, gc, sens, g, eff, y, smax, t, ip, sh, lnq, term;
            longint unsigned mant, m16;
            int p;
            t_vca_result r;
            smp  = smp_in;
            cv   = clampl(cv_in, $signed(regs[vcag_pkg::REG_CV_FLOOR][15:0]),
                          $signed(regs[vcag_pkg::REG_CV_CEILING][15:0]));
            gf   = regs[vcag_pkg::REG_GAIN_FLOOR];
            gc   = regs[vcag_pkg::REG_GAIN_CEILING];
            sens = regs[vcag_pkg::REG_CV_SENSITIVITY];
            if (sens > vcag_pkg::SENS_MAX) sens = vcag_pkg::SENS_MAX;
            g = clampl(regs[vcag_pkg::REG_BASE_GAIN], gf, gc);
            case (regs[vcag_pkg::REG_RESPONSE_MODE][1:0])
                vcag_pkg::MODE_LIN: begin
                    term = (cv * longint'(regs[vcag_pkg::REG_CV_FS_INVERSE]) * sens) >>> 23;
                    eff  = (g * (65536 + term)) >>> 16;
                end
                vcag_pkg::MODE_EXP: begin
                    t    = (cv * sens * longint'(vcag_pkg::EXP_K_Q32)) >>> 39;
                    ip   = clampl(t >>> 16, -40, 29);
                    mant = curve(1'b0, longint'(t) & 64'hFFFF);
                    sh   = 30 - ip;
                    eff  = (sh >= 64) ? 0 : longint'((longint'(g) * mant) >> sh);
                end
                vcag_pkg::MODE_LOG: begin
                    if (cv < 3) begin
                        lnq = longint'(vcag_pkg::LN_MIN);
                    end else begin
                        p = 0;
                        while (p < 15 && (cv >> (p + 1)) != 0) p++;
                        m16 = ((longint'(cv) << 16) >> p) - 65536;
                        lnq = longint'(p - 11) * longint'(vcag_pkg::LN2_Q16)
                            + longint'(curve(1'b1, m16) >> 14);
                    end
                    eff = (g * (65536 + ((lnq * sens) >>> 12))) >>> 16;
                end
                default: eff = g;
            endcase
            eff  = clampl(eff, gf, gc);
            smax = (longint'(1) << (SBITS - 1)) - 1;
            y    = (smp * eff) >>> 16;
            r.clip = 1'b0;
            if (y > smax) begin
                y = smax;
                r.clip = 1'b1;
            end
            if (y < -smax - 1) begin
                y = -smax - 1;
                r.clip = 1'b1;
            end
            r.sample = y[SBITS-1:0];
            r.gain   = eff[23:0];
            pending_out.push_back(r);
        endfunction

        function void check_result(logic signed [SBITS-1:0] smp,
                                   logic [23:0] gain, logic clip);
            t_vca_result e;
            if (pending_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: sample %0d gain %0d clip %0b",
                             smp, gain, clip);
                return;
            end
            e = pending_out.pop_front();
            if (e.sample !== smp || e.gain !== gain || e.clip !== clip) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: sample %0d/%0d gain %0d/%0d clip %0b/%0b (exp/got)",
                             e.sample, smp, e.gain, gain, e.clip, clip);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [SBITS-1:0] i_sample_in;
    logic signed [15:0]      i_control_volts;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [SBITS-1:0] o_sample_out;
    logic [23:0]             o_applied_gain;
    logic                    o_clipped;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [2:0]              i_cfg_index;
    logic [23:0]             i_cfg_data;

    t_vca_scoreboard gain_board;
    int              gap_pct;
    int              stall_pct;
    int              cycles;
    int              sent;

    voltage_controlled_amplifier_gain u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall) gain_board.note_input(i_sample_in, i_control_volts);
            if (o_valid && !i_stall) gain_board.check_result(o_sample_out, o_applied_gain,
                                                             o_clipped);
        end
    end

    task automatic send_item(logic signed [SBITS-1:0] smp, logic signed [15:0] cv);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_sample_in     = smp;
        i_control_volts = cv;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (gain_board.pending_out.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain_board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [23:0] pick_value(int idx, int kind);
        case (idx)
            vcag_pkg::REG_RESPONSE_MODE:
                return 24'((kind == 1) ? 0 : (kind == 2) ? 3 : $urandom_range(2));
            vcag_pkg::REG_BASE_GAIN:
                return 24'((kind == 1) ? 0 : (kind == 2) ? 24'hFFFFFF :
                           $urandom_range(2) == 0 ? $urandom_range(24'hFFFFFF) :
                           $urandom_range(200000));
            vcag_pkg::REG_CV_SENSITIVITY:
                return 24'((kind == 1) ? 0 : (kind == 2) ? 16'hFFFF :
                           $urandom_range(40960));
            vcag_pkg::REG_GAIN_FLOOR:
                return 24'((kind == 1) ? 0 : (kind == 2) ? 24'hFFFFFF :
                           $urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF) :
                           $urandom_range(30000));
            vcag_pkg::REG_GAIN_CEILING:
                return 24'((kind == 1) ? 0 : (kind == 2) ? 24'hFFFFFF :
                           $urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF) :
                           $urandom_range(2000000, 60000));
            vcag_pkg::REG_CV_FLOOR:
                return 24'((kind == 1) ? 24'h8000 : (kind == 2) ? 24'h7FFF :
                           $urandom_range(16'hFFFF));
            vcag_pkg::REG_CV_CEILING:
                return 24'((kind == 1) ? 24'h8000 : (kind == 2) ? 24'h7FFF :
                           $urandom_range(3) == 0 ? $urandom_range(16'hFFFF) :
                           $urandom_range(32767));
            default:
                return 24'((kind == 1) ? 0 : (kind == 2) ? 16'hFFFF :
                           $urandom_range(16'hFFFF));
        endcase
    endfunction

    initial begin
        logic signed [SBITS-1:0] edge_smp [3];
        logic signed [15:0]      edge_cv [7];
        int                      kind;
        int                      leftover;
        gain_board      = new();
        cycles          = 0;
        sent            = 0;
        gap_pct         = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_sample_in     = '0;
        i_control_volts = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        edge_smp = '{24'sh7FFFFF, -24'sh800000, 24'sh0};
        edge_cv  = '{16'sh7FFF, -16'sh8000, 16'sh0, 16'sh1, 16'sh2, 16'sh3, 16'sh1000};
        for (int m = 0; m < 3; m++) begin
            write_reg(vcag_pkg::REG_RESPONSE_MODE, 24'(m));
            for (int k = 0; k < 7; k++) send_item(edge_smp[k % 3], edge_cv[k]);
            drain();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            kind = (ph == 3) ? 1 : (ph == 7) ? 2 : 0;
            for (int r = 0; r < 8; r++) write_reg(3'(r), pick_value(r, kind));
            if (ph == 5) write_reg(vcag_pkg::REG_RESPONSE_MODE, 24'd3);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                if ($urandom_range(3) == 0)
                    send_item(24'($urandom_range(1) ? 24'sh7FFFFF - $urandom_range(255)
                                                    : -24'sh800000 + $urandom_range(255)),
                              16'($urandom_range(16'hFFFF)));
                else
                    send_item(24'($urandom_range(24'hFFFFFF)),
                              $urandom_range(1) ? 16'($urandom_range(16'hFFFF))
                                                : 16'($urandom_range(8192)));
            end
            gap_pct   = 0;
            stall_pct = 0;
            drain();
        end

        leftover = gain_board.pending_out.size();
        $display("Sent %0d items over %0d register settings in all four response modes,",
                 sent, PHASES + 3);
        $display("%0d results matched, %0d mismatches, %0d missing.",
                 gain_board.matched, gain_board.mismatches, leftover);
        if (gain_board.mismatches == 0 && leftover == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
